/* sv/ttf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttf_pkg: shared types and constants of the triangle tangent frame block
// Beat types of both channels, the triangle job passed from front to back,
// and the fixed-point constants.
// ----------------------------------------------------------------------------
package ttf_pkg;

  // Fraction bits of the unit vector components (Q1.14)
  localparam int unsigned OutFracBits = 14;
  // Default depth of the triangle queue between front and back
  localparam int unsigned QueueDepth  = 2;

  // One vertex beat
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic               tangent_given;
    logic               bitangent_given;
  } in_beat_t;

  // One result beat
  typedef struct packed {
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic signed [15:0] bitangent_x;
    logic signed [15:0] bitangent_y;
    logic signed [15:0] bitangent_z;
    logic               write_tangent;
    logic               write_bitangent;
    logic               degenerate;
  } out_beat_t;

  // Triangle job: edge and UV deltas, plus the request flags
  typedef struct packed {
    logic [2:0][32:0]   dp1;
    logic [2:0][32:0]   dp2;
    logic signed [32:0] du1;
    logic signed [32:0] dv1;
    logic signed [32:0] du2;
    logic signed [32:0] dv2;
    logic               want_t;
    logic               want_b;
  } job_t;

endpackage

/* sv/ttf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttf_front: vertex intake
// Holds the first two vertices of a triangle; the third one closes it and
// pushes the edge and UV deltas into the triangle queue.
// ----------------------------------------------------------------------------
module ttf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ttf_pkg::in_beat_t vertex_i,
  output logic              busy_o,
  output logic              push_o,
  output ttf_pkg::job_t     job_o,
  input  logic              full_i
);
  import ttf_pkg::*;

  logic [1:0] slot_q, slot_d;
  in_beat_t   v0_q, v1_q;
  logic       accept;

  // only a closing vertex needs room in the queue
  assign busy_o = full_i && slot_q[1];
  assign accept = start_i && !busy_o;
  assign push_o = accept && slot_q[1];

  // vertex slot counter
  always_comb begin
    slot_d = slot_q;
    if (accept) begin
      slot_d = slot_q[1] ? 2'd0 : slot_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= 2'd0;
    end else begin
      slot_q <= slot_d;
    end
  end

  // held vertices
  always_ff @(posedge clk_i) begin
    if (accept && slot_q == 2'd0) begin
      v0_q <= vertex_i;
    end
    if (accept && slot_q == 2'd1) begin
      v1_q <= vertex_i;
    end
  end

  // deltas against vertex 0, exact in 33 bits
  always_comb begin
    job_o.dp1[0] = {v1_q.pos_x[31], v1_q.pos_x} - {v0_q.pos_x[31], v0_q.pos_x};
    job_o.dp1[1] = {v1_q.pos_y[31], v1_q.pos_y} - {v0_q.pos_y[31], v0_q.pos_y};
    job_o.dp1[2] = {v1_q.pos_z[31], v1_q.pos_z} - {v0_q.pos_z[31], v0_q.pos_z};
    job_o.dp2[0] = {vertex_i.pos_x[31], vertex_i.pos_x} - {v0_q.pos_x[31], v0_q.pos_x};
    job_o.dp2[1] = {vertex_i.pos_y[31], vertex_i.pos_y} - {v0_q.pos_y[31], v0_q.pos_y};
    job_o.dp2[2] = {vertex_i.pos_z[31], vertex_i.pos_z} - {v0_q.pos_z[31], v0_q.pos_z};
    job_o.du1    = {v1_q.tex_u[31], v1_q.tex_u} - {v0_q.tex_u[31], v0_q.tex_u};
    job_o.dv1    = {v1_q.tex_v[31], v1_q.tex_v} - {v0_q.tex_v[31], v0_q.tex_v};
    job_o.du2    = {vertex_i.tex_u[31], vertex_i.tex_u} - {v0_q.tex_u[31], v0_q.tex_u};
    job_o.dv2    = {vertex_i.tex_v[31], vertex_i.tex_v} - {v0_q.tex_v[31], v0_q.tex_v};
    job_o.want_t = !vertex_i.tangent_given;
    job_o.want_b = !vertex_i.bitangent_given;
  end

endmodule

/* sv/ttf_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttf_fifo: triangle job queue
// Short register queue that decouples vertex intake from the vector engine.
// ----------------------------------------------------------------------------
module ttf_fifo #(
  parameter int unsigned Depth = ttf_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ttf_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output ttf_pkg::job_t data_o,
  output logic          empty_o
);
  import ttf_pkg::*;

  localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  job_t          mem_q [Depth];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // pointers and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(Depth - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(Depth - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* sv/ttf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttf_back: tangent frame engine
// Sequencer around one shared 33x33 multiplier: determinant, cross terms,
// block scaling, sum of squares, bit-serial square root and per-component
// restoring division to form the unit vectors.
// ----------------------------------------------------------------------------
module ttf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  ttf_pkg::job_t      job_i,
  output logic               pop_o,
  output logic               done_o,
  output ttf_pkg::out_beat_t result_o
);
  import ttf_pkg::*;

  localparam int unsigned NW = 31 + OutFracBits;   // dividend width
  localparam int unsigned QW = OutFracBits + 1;    // quotient width
  localparam int unsigned CW = $clog2(NW);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DET   = 4'd1;
  localparam logic [3:0] S_VEC   = 4'd2;
  localparam logic [3:0] S_MAG   = 4'd3;
  localparam logic [3:0] S_SCALE = 4'd4;
  localparam logic [3:0] S_SQ    = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_DIVI  = 4'd7;
  localparam logic [3:0] S_DIVR  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]         state_q, state_d;
  logic [1:0]         ph_q, ph_d;
  logic [1:0]         comp_q, comp_d;
  logic               vsel_q, vsel_d;
  logic               done_q, done_d;
  logic               degen_q, degen_d;
  job_t               job_q, job_d;
  logic signed [65:0] prod_q, prod_d, acc_q, acc_d;
  logic               flip_q, flip_d;
  logic signed [66:0] v_q [3];
  logic signed [66:0] v_d [3];
  logic [66:0]        m_q [3];
  logic [66:0]        m_d [3];
  logic [2:0]         neg_q, neg_d;
  logic [61:0]        sum_q, sum_d;
  logic [63:0]        x_q, x_d, r_q, r_d, sbit_q, sbit_d;
  logic [31:0]        n_q, n_d;
  logic [NW-1:0]      num_q, num_d;
  logic [31:0]        rem_q, rem_d;
  logic [QW-1:0]      quot_q, quot_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [15:0]        tan_q [3];
  logic [15:0]        tan_d [3];
  logic [15:0]        btan_q [3];
  logic [15:0]        btan_d [3];
  out_beat_t          out_q, out_d;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_w;
  logic signed [66:0] diff_w;

  // shared multiplier operand select
  always_comb begin
    mul_a = job_q.du1;
    mul_b = job_q.dv2;
    case (state_q)
      S_DET: begin
        if (ph_q != 2'd0) begin
          mul_a = job_q.du2;
          mul_b = job_q.dv1;
        end
      end
      S_VEC: begin
        if (!vsel_q) begin
          mul_a = (ph_q == 2'd0) ? job_q.dv2 : job_q.dv1;
          mul_b = (ph_q == 2'd0) ? $signed(job_q.dp1[comp_q]) : $signed(job_q.dp2[comp_q]);
        end else begin
          mul_a = (ph_q == 2'd0) ? job_q.du1 : job_q.du2;
          mul_b = (ph_q == 2'd0) ? $signed(job_q.dp2[comp_q]) : $signed(job_q.dp1[comp_q]);
        end
      end
      S_SQ: begin
        mul_a = $signed({3'b000, m_q[comp_q][29:0]});
        mul_b = $signed({3'b000, m_q[comp_q][29:0]});
      end
      default: begin
      end
    endcase
  end

  assign prod_w = mul_a * mul_b;
  assign diff_w = {acc_q[65], acc_q} - {prod_q[65], prod_q};

  // sequencer
  always_comb begin
    logic [66:0]   or_w;
    logic [63:0]   rb_w;
    logic [32:0]   rsh_w;
    logic          ge_w;
    logic [QW-1:0] qn_w;
    logic [QW-1:0] qs_w;
    logic [31:0]   qx_w;
    logic [31:0]   sq_w;

    state_d = state_q;
    ph_d    = ph_q;
    comp_d  = comp_q;
    vsel_d  = vsel_q;
    done_d  = 1'b0;
    degen_d = degen_q;
    job_d   = job_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    flip_d  = flip_q;
    v_d     = v_q;
    m_d     = m_q;
    neg_d   = neg_q;
    sum_d   = sum_q;
    x_d     = x_q;
    r_d     = r_q;
    sbit_d  = sbit_q;
    n_d     = n_q;
    num_d   = num_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    tan_d   = tan_q;
    btan_d  = btan_q;
    out_d   = out_q;
    pop_o   = 1'b0;

    or_w  = m_q[0] | m_q[1] | m_q[2];
    rb_w  = r_q + sbit_q;
    rsh_w = {rem_q, num_q[NW-1]};
    ge_w  = (rsh_w >= {1'b0, n_q});
    qn_w  = {quot_q[QW-2:0], ge_w};
    qs_w  = (qn_w > (QW'(1) << OutFracBits)) ? (QW'(1) << OutFracBits) : qn_w;
    qx_w  = 32'(qs_w);
    sq_w  = (neg_q[comp_q] ^ flip_q) ? (32'd0 - qx_w) : qx_w;

    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          job_d   = job_i;
          degen_d = 1'b0;
          ph_d    = 2'd0;
          for (int i = 0; i < 3; i++) begin
            tan_d[i]  = '0;
            btan_d[i] = '0;
          end
          state_d = S_DET;
        end
      end
      // a*b - c*d, shared by determinant and cross terms
      S_DET, S_VEC: begin
        if (ph_q == 2'd0) begin
          prod_d = prod_w;
          ph_d   = 2'd1;
        end else if (ph_q == 2'd1) begin
          acc_d  = prod_q;
          prod_d = prod_w;
          ph_d   = 2'd2;
        end else begin
          ph_d = 2'd0;
          if (state_q == S_DET) begin
            flip_d = diff_w[66];
            if (!(job_q.want_t || job_q.want_b)) begin
              state_d = S_OUT;
            end else if (diff_w == '0) begin
              degen_d = 1'b1;
              state_d = S_OUT;
            end else begin
              vsel_d  = !job_q.want_t;
              comp_d  = 2'd0;
              state_d = S_VEC;
            end
          end else begin
            v_d[comp_q] = diff_w;
            if (comp_q == 2'd2) begin
              state_d = S_MAG;
            end else begin
              comp_d = comp_q + 2'd1;
            end
          end
        end
      end
      S_MAG: begin
        for (int i = 0; i < 3; i++) begin
          neg_d[i] = v_q[i][66];
          m_d[i]   = v_q[i][66] ? (67'd0 - v_q[i]) : v_q[i];
        end
        state_d = S_SCALE;
      end
      // common shift until the largest magnitude sits in [2^29, 2^30); all zero is degenerate
      S_SCALE: begin
        if (or_w == '0) begin
          degen_d = 1'b1;
          state_d = S_OUT;
        end else if (|or_w[66:30]) begin
          for (int i = 0; i < 3; i++) m_d[i] = m_q[i] >> 1;
        end else if (!or_w[29]) begin
          for (int i = 0; i < 3; i++) m_d[i] = m_q[i] << 1;
        end else begin
          comp_d  = 2'd0;
          ph_d    = 2'd0;
          sum_d   = '0;
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        if (ph_q == 2'd0) begin
          prod_d = prod_w;
          ph_d   = 2'd1;
        end else begin
          sum_d = sum_q + prod_q[61:0];
          ph_d  = 2'd0;
          if (comp_q == 2'd2) begin
            x_d     = {2'b00, sum_q + prod_q[61:0]};
            r_d     = '0;
            sbit_d  = 64'd1 << 62;
            state_d = S_SQRT;
          end else begin
            comp_d = comp_q + 2'd1;
          end
        end
      end
      // one result bit per cycle
      S_SQRT: begin
        if (sbit_q == '0) begin
          n_d     = r_q[31:0];
          comp_d  = 2'd0;
          state_d = S_DIVI;
        end else begin
          if (x_q >= rb_w) begin
            x_d = x_q - rb_w;
            r_d = (r_q >> 1) + sbit_q;
          end else begin
            r_d = r_q >> 1;
          end
          sbit_d = sbit_q >> 2;
        end
      end
      S_DIVI: begin
        num_d   = (NW'(m_q[comp_q][29:0]) << OutFracBits) + NW'(n_q[31:1]);
        rem_d   = '0;
        quot_d  = '0;
        cnt_d   = CW'(NW - 1);
        state_d = S_DIVR;
      end
      // restoring division, one quotient bit per cycle
      S_DIVR: begin
        rem_d  = ge_w ? 32'(rsh_w - {1'b0, n_q}) : rsh_w[31:0];
        quot_d = qn_w;
        num_d  = num_q << 1;
        cnt_d  = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          if (!vsel_q) begin
            tan_d[comp_q] = sq_w[15:0];
          end else begin
            btan_d[comp_q] = sq_w[15:0];
          end
          if (comp_q == 2'd2) begin
            if (!vsel_q && job_q.want_b) begin
              vsel_d  = 1'b1;
              comp_d  = 2'd0;
              ph_d    = 2'd0;
              state_d = S_VEC;
            end else begin
              state_d = S_OUT;
            end
          end else begin
            comp_d  = comp_q + 2'd1;
            state_d = S_DIVI;
          end
        end
      end
      S_OUT: begin
        out_d.tangent_x       = degen_q ? '0 : $signed(tan_q[0]);
        out_d.tangent_y       = degen_q ? '0 : $signed(tan_q[1]);
        out_d.tangent_z       = degen_q ? '0 : $signed(tan_q[2]);
        out_d.bitangent_x     = degen_q ? '0 : $signed(btan_q[0]);
        out_d.bitangent_y     = degen_q ? '0 : $signed(btan_q[1]);
        out_d.bitangent_z     = degen_q ? '0 : $signed(btan_q[2]);
        out_d.write_tangent   = job_q.want_t && !degen_q;
        out_d.write_bitangent = job_q.want_b && !degen_q;
        out_d.degenerate      = degen_q;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= 2'd0;
      comp_q  <= 2'd0;
      vsel_q  <= 1'b0;
      done_q  <= 1'b0;
      degen_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      comp_q  <= comp_d;
      vsel_q  <= vsel_d;
      done_q  <= done_d;
      degen_q <= degen_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    flip_q <= flip_d;
    v_q    <= v_d;
    m_q    <= m_d;
    neg_q  <= neg_d;
    sum_q  <= sum_d;
    x_q    <= x_d;
    r_q    <= r_d;
    sbit_q <= sbit_d;
    n_q    <= n_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    cnt_q  <= cnt_d;
    tan_q  <= tan_d;
    btan_q <= btan_d;
    out_q  <= out_d;
  end

  assign done_o   = done_q;
  assign result_o = out_q;

endmodule

/* sv/triangle_tangent_frame.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_tangent_frame: unit tangent and bitangent per triangle
// Usage:
//   A vertex beat is taken when start_i is high and busy_o is low. Every
//   third vertex closes a triangle; its tangent_given / bitangent_given bits
//   pick which vectors are computed.
//   One result per triangle appears on result_o for a single cycle with
//   done_o high; the receiver must take it then, it cannot stall.
//   The first two vertices are always taken; busy_o stays low for them. A closing vertex
//   goes into a triangle queue (QueueDepth entries); busy_o is high while a
//   closing vertex is due and that queue is full.
//   The engine computes, per requested vector, the cross terms, the
//   magnitudes, block scaling, the sum of squares, the bit-serial square
//   root and a restoring division per component; it takes the next
//   triangle from the queue only once it is idle again.
//   Reset empties the queue and restarts the vertex count at the first
//   vertex of a triangle.
// ----------------------------------------------------------------------------
module triangle_tangent_frame #(
  parameter int unsigned QueueDepth = ttf_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  ttf_pkg::in_beat_t  vertex_i,
  output logic               busy_o,
  output logic               done_o,
  output ttf_pkg::out_beat_t result_o
);
  import ttf_pkg::*;

  logic push, full, pop, empty;
  job_t job_in, job_out;

  // vertex intake
  ttf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .vertex_i (vertex_i),
    .busy_o   (busy_o),
    .push_o   (push),
    .job_o    (job_in),
    .full_i   (full)
  );

  // triangle queue
  ttf_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (job_out),
    .empty_o (empty)
  );

  // vector engine
  ttf_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .job_i    (job_out),
    .pop_o    (pop),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

/* sv/ttf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttf_checker: port-level checks of the triangle tangent frame
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module ttf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               done_o,
  input ttf_pkg::out_beat_t result_o
);
  import ttf_pkg::*;

  // results of two triangles never come in adjacent cycles
  a_done_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result beats in adjacent cycles");

  // degenerate beat carries no write flags and zero x components of both vectors
  a_degen_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.degenerate |->
      !result_o.write_tangent && !result_o.write_bitangent &&
      result_o.tangent_x == 16'sd0 && result_o.bitangent_x == 16'sd0)
    else $error("degenerate beat with vector data");

  // a tangent not written is all zero
  a_tan_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.write_tangent |->
      result_o.tangent_x == 16'sd0 && result_o.tangent_y == 16'sd0 &&
      result_o.tangent_z == 16'sd0)
    else $error("unwritten tangent not zero");

  // a bitangent not written is all zero
  a_btan_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.write_bitangent |->
      result_o.bitangent_x == 16'sd0 && result_o.bitangent_y == 16'sd0 &&
      result_o.bitangent_z == 16'sd0)
    else $error("unwritten bitangent not zero");

endmodule

bind triangle_tangent_frame ttf_checker u_ttf_checker (.*);
